@@ rtl/core/can_motor_axis_supervisor_macros.svh @@
// Assertion macros for the checker file of the axis supervisor.
// No dependencies; include by bare file name.
`ifndef CAN_MOTOR_AXIS_SUPERVISOR_MACROS_SVH
`define CAN_MOTOR_AXIS_SUPERVISOR_MACROS_SVH

// condition holds at every edge out of reset
`define CMAS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define CMAS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

@@ rtl/core/cmas_pkg.sv @@
// Types and constants of the CAN motor axis supervisor.
// No dependencies; imported by the walker, the top module and the checker.
package cmas_pkg;

  localparam int unsigned NUM_TORQUE = 3;

  localparam logic [4:0] CMD_TORQUE    = 5'h0E;
  localparam logic [4:0] CMD_CLEAR     = 5'h18;
  localparam logic [4:0] CMD_SET_STATE = 5'h07;

  localparam logic [2:0] REG_TORQUE0   = 3'd0;
  localparam logic [2:0] REG_TORQUE1   = 3'd1;
  localparam logic [2:0] REG_TORQUE2   = 3'd2;
  localparam logic [2:0] REG_ENC_CMD   = 3'd3;
  localparam logic [2:0] REG_HB_CMD    = 3'd4;
  localparam logic [2:0] REG_RETRY_LIM = 3'd5;
  localparam logic [2:0] REG_CL_STATE  = 3'd6;

  localparam logic [4:0] ENC_CMD_RST   = 5'd10;
  localparam logic [4:0] HB_CMD_RST    = 5'd1;
  localparam logic [7:0] RETRY_LIM_RST = 8'd100;
  localparam logic [7:0] CL_STATE_RST  = 8'd8;

  typedef struct packed {
    logic [NUM_TORQUE-1:0][31:0] torque;
    logic [4:0]                  enc_cmd;
    logic [4:0]                  hb_cmd;
    logic [7:0]                  retry_limit;
    logic [7:0]                  cl_state;
  } cmas_cfg_t;

  typedef struct packed {
    logic [10:0] id;
    logic        remote;
    logic [31:0] data_low;
    logic        last;
  } cmas_frame_t;

endpackage

@@ rtl/core/cmas_if.sv @@
// Valid/ready channel interfaces for received and transmitted CAN frames.
// No dependencies.
interface cmas_rx_if;
  logic        valid;
  logic        ready;
  logic [10:0] frame_id;
  logic [31:0] data_low;
  logic [31:0] data_high;

  modport source (output valid, frame_id, data_low, data_high, input ready);
  modport sink (input valid, frame_id, data_low, data_high, output ready);
endinterface

interface cmas_tx_if;
  logic        valid;
  logic        ready;
  logic [10:0] tx_id;
  logic        tx_remote;
  logic [31:0] tx_data_low;
  logic [31:0] tx_data_high;
  logic        last_frame;

  modport source (output valid, tx_id, tx_remote, tx_data_low, tx_data_high, last_frame,
                  input ready);
  modport sink (input valid, tx_id, tx_remote, tx_data_low, tx_data_high, last_frame,
                output ready);
endinterface

@@ rtl/core/cmas_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cmas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/cmas_walker.sv @@
// Frame decode and per-axis health walk over the axis state memories.
// Depends on cmas_pkg and cmas_ram.
module cmas_walker import cmas_pkg::*; #(
  parameter int unsigned NUM_AXES = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmas_cfg_t   cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [10:0] frame_id_i,
  input  logic [31:0] data_high_i,
  input  logic        slot_free_i,
  output logic        push_o,
  output cmas_frame_t push_frame_o
);

  localparam int unsigned AW = NUM_AXES > 1 ? $clog2(NUM_AXES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EV   = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [NUM_AXES-1:0] vld_a_q, vld_b_q;
  logic                pend_vld_q;
  cmas_frame_t         pend_q;

  logic [5:0]  axis_in;
  logic [4:0]  cmd_in;
  logic        in_range, accept, is_enc, is_hb;
  logic        ev, is_last, hit_clr, hit_set, emit, adv;
  logic [15:0] a_rdata;
  logic [7:0]  b_rdata, stage_rd, err_rd, cnt_rd, cnt_new;
  logic [31:0] torque_sel;
  cmas_frame_t walk_frame;

  assign axis_in  = frame_id_i[10:5];
  assign cmd_in   = frame_id_i[4:0];
  assign in_range = {1'b0, axis_in} < 7'(NUM_AXES);
  assign is_enc   = cmd_in == cfg_i.enc_cmd;
  assign is_hb    = !is_enc && (cmd_in == cfg_i.hb_cmd);

  assign in_ready_o = (state_q == ST_IDLE) && (!pend_vld_q || slot_free_i);
  assign accept     = in_valid_i && in_ready_o;

  assign torque_sel = ({1'b0, axis_in} < 7'(NUM_TORQUE)) ? cfg_i.torque[axis_in[1:0]] : '0;

  cmas_ram #(.WIDTH(16), .DEPTH(NUM_AXES)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (accept && in_range && is_hb),
    .waddr_i (axis_in[AW-1:0]),
    .wdata_i ({data_high_i[23:16], data_high_i[7:0]}),
    .re_i    (state_q == ST_RD),
    .raddr_i (idx_q),
    .rdata_o (a_rdata)
  );

  cmas_ram #(.WIDTH(8), .DEPTH(NUM_AXES)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (adv && emit),
    .waddr_i (idx_q),
    .wdata_i (cnt_new),
    .re_i    (state_q == ST_RD),
    .raddr_i (idx_q),
    .rdata_o (b_rdata)
  );

  assign stage_rd = vld_a_q[idx_q] ? a_rdata[7:0]  : '0;
  assign err_rd   = vld_a_q[idx_q] ? a_rdata[15:8] : '0;
  assign cnt_rd   = vld_b_q[idx_q] ? b_rdata       : '0;

  assign ev      = state_q == ST_EV;
  assign is_last = idx_q == AW'(NUM_AXES - 1);
  assign hit_clr = err_rd == 8'd1;
  assign hit_set = !hit_clr && (stage_rd != cfg_i.cl_state) && (stage_rd != 8'd0)
                   && (cnt_rd <= cfg_i.retry_limit);
  assign emit    = ev && (hit_clr || hit_set);
  assign adv     = ev && (!emit || !pend_vld_q || slot_free_i);
  assign cnt_new = hit_clr ? 8'd0 : ((cnt_rd == 8'hFF) ? cnt_rd : cnt_rd + 8'd1);

  always_comb begin
    walk_frame.id       = {6'(idx_q), hit_clr ? CMD_CLEAR : CMD_SET_STATE};
    walk_frame.remote   = hit_clr;
    walk_frame.data_low = hit_clr ? 32'd0 : {24'd0, cfg_i.cl_state};
    walk_frame.last     = is_last;
  end

  assign push_o       = pend_vld_q && slot_free_i && (pend_q.last || emit);
  assign push_frame_o = pend_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_range && is_hb) begin
          state_d = ST_RD;
          idx_d   = '0;
        end
      end
      ST_RD: begin
        state_d = ST_EV;
      end
      ST_EV: begin
        if (adv) begin
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_RD;
            idx_d   = AW'(idx_q + 1'b1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      vld_a_q    <= '0;
      vld_b_q    <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (accept && in_range && is_hb) begin
        vld_a_q[axis_in[AW-1:0]] <= 1'b1;
      end
      if (adv && emit) begin
        vld_b_q[idx_q] <= 1'b1;
      end
      if ((accept && in_range && is_enc) || (emit && adv)) begin
        pend_vld_q <= 1'b1;
      end else if (push_o) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_range && is_enc) begin
      pend_q.id       <= {axis_in, CMD_TORQUE};
      pend_q.remote   <= 1'b0;
      pend_q.data_low <= torque_sel;
      pend_q.last     <= 1'b1;
    end else if (emit && adv) begin
      pend_q <= walk_frame;
    end else if (adv && is_last && pend_vld_q) begin
      pend_q.last <= 1'b1;
    end
  end

endmodule

@@ rtl/core/can_motor_axis_supervisor.sv @@
// Path: an accepted encoder-count frame reaches tx through the pending register, then the tx register.
// Flow: a heartbeat holds off new frames until its walk is done, a read then an update of each
// axis entry in the state memories; an encoder frame waits while the pending frame is stalled.
// Reset: asynchronous, active low; control and config registers return to defaults and per-axis valid
// flags clear, so every axis entry reads as zero until written.
module can_motor_axis_supervisor import cmas_pkg::*; #(
  parameter int unsigned NUM_AXES = 3
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cmas_rx_if.sink      rx_i,
  cmas_tx_if.source    tx_o,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  cmas_cfg_t   cfg_q;
  cmas_frame_t tx_q;
  logic        tx_vld_q;
  logic        slot_free, push;
  cmas_frame_t push_frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.torque      <= '0;
      cfg_q.enc_cmd     <= ENC_CMD_RST;
      cfg_q.hb_cmd      <= HB_CMD_RST;
      cfg_q.retry_limit <= RETRY_LIM_RST;
      cfg_q.cl_state    <= CL_STATE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TORQUE0:   cfg_q.torque[0]   <= cfg_data_i;
        REG_TORQUE1:   cfg_q.torque[1]   <= cfg_data_i;
        REG_TORQUE2:   cfg_q.torque[2]   <= cfg_data_i;
        REG_ENC_CMD:   cfg_q.enc_cmd     <= cfg_data_i[4:0];
        REG_HB_CMD:    cfg_q.hb_cmd      <= cfg_data_i[4:0];
        REG_RETRY_LIM: cfg_q.retry_limit <= cfg_data_i[7:0];
        REG_CL_STATE:  cfg_q.cl_state    <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  assign slot_free = !tx_vld_q || tx_o.ready;

  cmas_walker #(.NUM_AXES(NUM_AXES)) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (rx_i.valid),
    .in_ready_o   (rx_i.ready),
    .frame_id_i   (rx_i.frame_id),
    .data_high_i  (rx_i.data_high),
    .slot_free_i  (slot_free),
    .push_o       (push),
    .push_frame_o (push_frame)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_vld_q <= 1'b0;
    end else if (push) begin
      tx_vld_q <= 1'b1;
    end else if (tx_o.ready) begin
      tx_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      tx_q <= push_frame;
    end
  end

  assign tx_o.valid        = tx_vld_q;
  assign tx_o.tx_id        = tx_q.id;
  assign tx_o.tx_remote    = tx_q.remote;
  assign tx_o.tx_data_low  = tx_q.data_low;
  assign tx_o.tx_data_high = '0;
  assign tx_o.last_frame   = tx_q.last;

endmodule

@@ rtl/core/cmas_checker.sv @@
// Port-level checks on the transmit channel of the axis supervisor, with its bind.
// Depends on cmas_pkg and can_motor_axis_supervisor_macros.svh.
`include "can_motor_axis_supervisor_macros.svh"

module cmas_checker import cmas_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        tx_valid_i,
  input logic        tx_ready_i,
  input logic [10:0] tx_id_i,
  input logic        tx_remote_i,
  input logic [31:0] tx_data_low_i,
  input logic [31:0] tx_data_high_i
);

  `CMAS_ASSERT_NEXT(a_tx_hold, clk_i, rst_ni, tx_valid_i && !tx_ready_i, tx_valid_i && $stable(tx_id_i))
  `CMAS_ASSERT_ALWAYS(a_remote_clear, clk_i, rst_ni, !(tx_valid_i && tx_remote_i) || ((tx_id_i[4:0] == CMD_CLEAR) && (tx_data_low_i == 32'd0)))
  `CMAS_ASSERT_ALWAYS(a_data_high_zero, clk_i, rst_ni, !tx_valid_i || (tx_data_high_i == 32'd0))
  `CMAS_ASSERT_ALWAYS(a_cmd_known, clk_i, rst_ni, !tx_valid_i || (tx_id_i[4:0] == CMD_CLEAR) || (tx_id_i[4:0] == CMD_TORQUE) || (tx_id_i[4:0] == CMD_SET_STATE))

endmodule

bind can_motor_axis_supervisor cmas_checker u_cmas_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .tx_valid_i     (tx_o.valid),
  .tx_ready_i     (tx_o.ready),
  .tx_id_i        (tx_o.tx_id),
  .tx_remote_i    (tx_o.tx_remote),
  .tx_data_low_i  (tx_o.tx_data_low),
  .tx_data_high_i (tx_o.tx_data_high)
);
